### sv/polygon_fan_to_bilinear_quads_defines.svh
// Assertion helpers shared by the block
`ifndef POLYGON_FAN_TO_BILINEAR_QUADS_DEFINES_SVH
`define POLYGON_FAN_TO_BILINEAR_QUADS_DEFINES_SVH

// same-cycle implication, held off during reset
`define PFTBQ_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pftbq assertion failed");

// next-cycle implication, held off during reset
`define PFTBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pftbq assertion failed");

`endif

### sv/pftbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pftbq_pkg;

	localparam int NUM_AXES     = 3;
	localparam int JOB_PTS      = 4;
	localparam int QUAD_CORNERS = 4;
	localparam int TRI_CORNERS  = 12;
	localparam int CORNER_W     = 4;
	localparam int DIV_DIGITS   = 8;

	localparam logic JOB_QUAD = 1'b0;
	localparam logic JOB_TRI  = 1'b1;

	localparam logic [1:0] PT_APEX  = 2'd0;
	localparam logic [1:0] PT_START = 2'd1;
	localparam logic [1:0] PT_NEW   = 2'd2;
	localparam logic [1:0] PT_MID   = 2'd3;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
		logic       centroid;
	} corner_sel_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	function automatic corner_sel_t tri_sel(input logic [CORNER_W-1:0] k);
		corner_sel_t s;
		s = '{a: PT_APEX, b: PT_APEX, centroid: 1'b0};
		case (k)
			4'd0: s = '{a: PT_APEX, b: PT_APEX, centroid: 1'b0};
			4'd1: s = '{a: PT_APEX, b: PT_START, centroid: 1'b0};
			4'd2: s = '{a: PT_APEX, b: PT_NEW, centroid: 1'b0};
			4'd3: s = '{a: PT_APEX, b: PT_APEX, centroid: 1'b1};
			4'd4: s = '{a: PT_START, b: PT_START, centroid: 1'b0};
			4'd5: s = '{a: PT_APEX, b: PT_START, centroid: 1'b0};
			4'd6: s = '{a: PT_START, b: PT_NEW, centroid: 1'b0};
			4'd7: s = '{a: PT_APEX, b: PT_APEX, centroid: 1'b1};
			4'd8: s = '{a: PT_NEW, b: PT_NEW, centroid: 1'b0};
			4'd9: s = '{a: PT_START, b: PT_NEW, centroid: 1'b0};
			4'd10: s = '{a: PT_APEX, b: PT_NEW, centroid: 1'b0};
			4'd11: s = '{a: PT_APEX, b: PT_APEX, centroid: 1'b1};
			default: s = '{a: PT_APEX, b: PT_APEX, centroid: 1'b0};
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### sv/pftbq_vertex_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pftbq_vertex_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic                          polygon_end;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output polygon_end, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input polygon_end, output ready);
endinterface

`default_nettype wire

### sv/pftbq_corner_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pftbq_corner_if #(parameter int COORD_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    corner_index;
	logic signed [COORD_WIDTH-1:0] corner_x;
	logic signed [COORD_WIDTH-1:0] corner_y;
	logic signed [COORD_WIDTH-1:0] corner_z;
	logic                          run_last;

	modport source (output valid, output corner_index, output corner_x, output corner_y,
		output corner_z, output run_last, input ready);
	modport sink (input valid, input corner_index, input corner_x, input corner_y,
		input corner_z, input run_last, output ready);
endinterface

`default_nettype wire

### sv/pftbq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbq_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pftbq_vertex_if.sink         vertex,
	input  pftbq_pkg::q_stat_t   q_stat,
	output logic                 push,
	output logic                 job_kind,
	output logic [pftbq_pkg::JOB_PTS-1:0][pftbq_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] job_pts
);
	import pftbq_pkg::*;

	localparam logic [1:0] PH_APEX  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_MID   = 2'd2;
	localparam logic [1:0] PH_CLOSE = 2'd3;

	logic [1:0]                                phase_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]      apex_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]      start_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]      mid_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]      v;
	logic                                      accept;

	assign v = {vertex.pos_z, vertex.pos_y, vertex.pos_x};
	assign vertex.ready = !q_stat.full;
	assign accept = vertex.valid && vertex.ready;
	assign push = accept && ((phase_q == PH_CLOSE) ||
		((phase_q == PH_MID) && vertex.polygon_end));
	assign job_kind = (phase_q == PH_CLOSE) ? JOB_QUAD : JOB_TRI;
	assign job_pts = {mid_q, v, start_q, apex_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_APEX;
		end else if (accept) begin
			if (vertex.polygon_end) begin
				phase_q <= PH_APEX;
			end else begin
				case (phase_q)
					PH_APEX:  phase_q <= PH_START;
					PH_START: phase_q <= PH_MID;
					PH_MID:   phase_q <= PH_CLOSE;
					PH_CLOSE: phase_q <= PH_MID;
					default:  phase_q <= PH_APEX;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_APEX:  apex_q <= v;
				PH_START: start_q <= v;
				PH_MID: begin
					if (!vertex.polygon_end) begin
						mid_q <= v;
					end
				end
				PH_CLOSE: start_q <= v;
				default:  apex_q <= v;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/pftbq_jobq.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbq_jobq #(
	parameter int WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   push_data,
	input  logic               pop,
	output logic [WIDTH-1:0]   head,
	output pftbq_pkg::q_stat_t q_stat
);
	import pftbq_pkg::*;

	logic [WIDTH-1:0] mem [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign head = mem[rd_q];
	assign q_stat.full = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/pftbq_div3.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbq_div3 #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pftbq_pkg::JOB_PTS-1:0][pftbq_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] pts,
	output logic valid,
	output logic [pftbq_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] res
);
	import pftbq_pkg::*;

	localparam int SUM_W = COORD_WIDTH + 2;
	localparam int NSTEP = (SUM_W + DIV_DIGITS - 1) / DIV_DIGITS;
	localparam int PAD_W = NSTEP * DIV_DIGITS;
	localparam int CNT_W = $clog2(NSTEP + 1);
	localparam logic [COORD_WIDTH-1:0] BIAS = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [NUM_AXES-1:0][PAD_W-1:0]       dvd_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] quo_q;
	logic [NUM_AXES-1:0][1:0]             rem_q;
	logic [NUM_AXES-1:0][PAD_W-1:0]       sum;
	logic [NUM_AXES-1:0][DIV_DIGITS-1:0]  qd;
	logic [NUM_AXES-1:0][1:0]             rem_nxt;
	logic [CNT_W-1:0]                     cnt_q;
	logic                                 busy_q;
	logic                                 valid_q;

	always_comb begin
		logic [2:0] t;
		logic [1:0] r;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			sum[ax] = PAD_W'(pts[PT_APEX][ax] ^ BIAS) + PAD_W'(pts[PT_START][ax] ^ BIAS)
				+ PAD_W'(pts[PT_NEW][ax] ^ BIAS);
			r = rem_q[ax];
			for (int i = 0; i < DIV_DIGITS; i++) begin
				t = {r, dvd_q[ax][PAD_W-1-i]};
				if (t >= 3'd3) begin
					qd[ax][DIV_DIGITS-1-i] = 1'b1;
					r = 2'(t - 3'd3);
				end else begin
					qd[ax][DIV_DIGITS-1-i] = 1'b0;
					r = t[1:0];
				end
			end
			rem_nxt[ax] = r;
			res[ax] = quo_q[ax] ^ BIAS;
		end
	end

	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= sum;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				dvd_q[ax] <= {dvd_q[ax][PAD_W-DIV_DIGITS-1:0], {DIV_DIGITS{1'b0}}};
				quo_q[ax] <= {quo_q[ax][COORD_WIDTH-DIV_DIGITS-1:0], qd[ax]};
				rem_q[ax] <= rem_nxt[ax];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (start) begin
			cnt_q   <= CNT_W'(NSTEP);
			busy_q  <= 1'b1;
			valid_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q  <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/pftbq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pftbq_back #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pftbq_pkg::q_stat_t   q_stat,
	input  logic                 job_kind,
	input  logic [pftbq_pkg::JOB_PTS-1:0][pftbq_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] job_pts,
	input  logic [pftbq_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] centroid,
	output pftbq_pkg::div_ctl_t  div_ctl_start,
	input  logic                 div_valid,
	output logic                 pop,
	pftbq_corner_if.source       corner
);
	import pftbq_pkg::*;

	logic [CORNER_W-1:0]                  k_q;
	logic                                 go_q;
	logic                                 out_valid_q;
	logic [1:0]                           idx_q;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] pos_q;
	logic                                 last_q;
	corner_sel_t                          sel;
	logic                                 last;
	logic                                 can_emit;
	logic [NUM_AXES-1:0][COORD_WIDTH:0]   hsum;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] val;

	always_comb begin
		if (job_kind == JOB_TRI) begin
			sel  = tri_sel(k_q);
			last = (k_q == CORNER_W'(TRI_CORNERS - 1));
		end else begin
			sel  = '{a: k_q[1:0], b: k_q[1:0], centroid: 1'b0};
			last = (k_q == CORNER_W'(QUAD_CORNERS - 1));
		end
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			hsum[ax] = {job_pts[sel.a][ax][COORD_WIDTH-1], job_pts[sel.a][ax]}
				+ {job_pts[sel.b][ax][COORD_WIDTH-1], job_pts[sel.b][ax]};
			val[ax] = sel.centroid ? centroid[ax] : hsum[ax][COORD_WIDTH:1];
		end
	end

	assign can_emit = !q_stat.empty && (!sel.centroid || div_valid)
		&& (!out_valid_q || corner.ready);
	assign pop = can_emit && last;
	assign div_ctl_start.start = !q_stat.empty && (job_kind == JOB_TRI) && !go_q;

	assign corner.valid        = out_valid_q;
	assign corner.corner_index = idx_q;
	assign corner.corner_x     = pos_q[0];
	assign corner.corner_y     = pos_q[1];
	assign corner.corner_z     = pos_q[2];
	assign corner.run_last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_ctl_start.start) begin
				go_q <= 1'b1;
			end else if (pop) begin
				go_q <= 1'b0;
			end
			if (can_emit) begin
				k_q <= last ? '0 : k_q + CORNER_W'(1);
				out_valid_q <= 1'b1;
			end else if (corner.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			idx_q  <= k_q[1:0];
			pos_q  <= val;
			last_q <= last;
		end
	end

endmodule

`default_nettype wire

### sv/polygon_fan_to_bilinear_quads.sv
// Polygon fan to bilinear quads.
// Input channel "vertex": one polygon vertex per transfer (signed Q16.16 x, y, z)
// with polygon_end on the last vertex of each polygon.
// Output channel "corner": one patch corner per transfer; corner_index 3 closes
// a patch and run_last marks the final corner caused by one vertex.
// A vertex is taken in every cycle while the two-entry job queue has room;
// apex, start and middle vertices only update the fan state and send nothing.
// A closing vertex queues a quad (4 corners, one per cycle unless the receiver
// stalls); a polygon that ends on an unpaired vertex queues a triangle split
// (12 corners). A vertex's first corner passes through the job queue and then
// the output register. In a split, the centroid corner waits for the divide-by-3
// unit, which starts when the job reaches the queue head. Throughput is set by
// the single corner port: one corner per cycle unless receiver or divider stalls.
// Reset clears the fan phase, the queue and the output valid bit.
// When the receiver stalls, the current corner holds in the output register,
// the queue fills, and vertex.ready drops once both queue entries are taken.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_fan_to_bilinear_quads_defines.svh"

module polygon_fan_to_bilinear_quads #(
	parameter int COORD_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	pftbq_vertex_if.sink   vertex,
	pftbq_corner_if.source corner
);
	import pftbq_pkg::*;

	localparam int JOB_W = JOB_PTS * NUM_AXES * COORD_WIDTH + 1;

	q_stat_t                                               q_stat;
	div_ctl_t                                              div_ctl;
	logic                                                  push;
	logic                                                  pop;
	logic                                                  f_kind;
	logic [JOB_PTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]     f_pts;
	logic                                                  h_kind;
	logic [JOB_PTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0]     h_pts;
	logic [JOB_W-1:0]                                      push_data;
	logic [JOB_W-1:0]                                      head;
	logic                                                  div_valid;
	logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                  centroid;

	assign push_data = {f_kind, f_pts};
	assign {h_kind, h_pts} = head;

	pftbq_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vertex   (vertex),
		.q_stat   (q_stat),
		.push     (push),
		.job_kind (f_kind),
		.job_pts  (f_pts)
	);

	pftbq_jobq #(.WIDTH(JOB_W)) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	pftbq_div3 #(.COORD_WIDTH(COORD_WIDTH)) u_div3 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_ctl.start),
		.pts    (h_pts),
		.valid  (div_valid),
		.res    (centroid)
	);

	pftbq_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.job_kind      (h_kind),
		.job_pts       (h_pts),
		.centroid      (centroid),
		.div_ctl_start (div_ctl),
		.div_valid     (div_valid),
		.pop           (pop),
		.corner        (corner)
	);

	`PFTBQ_ASSERT(a_push_room, clk, arst_n, push, !q_stat.full)
	`PFTBQ_ASSERT(a_pop_data, clk, arst_n, pop, !q_stat.empty)
	`PFTBQ_ASSERT(a_close_idx, clk, arst_n, corner.valid && corner.run_last, corner.corner_index == 2'd3)
	`PFTBQ_ASSERT_NEXT(a_push_lands, clk, arst_n, push && !pop, !q_stat.empty)

endmodule

`default_nettype wire

### tb/pftbq_quad_checker.sv
`timescale 1ns / 1ps

module pftbq_quad_checker #(
	parameter int CW = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	pftbq_vertex_if vertex_mon,
	pftbq_corner_if corner_mon,
	output int      fail_count,
	output int      corners_owed
);

	typedef enum logic [1:0] {
		AWAIT_APEX,
		AWAIT_START,
		AWAIT_MIDDLE,
		AWAIT_CLOSE
	} fan_phase_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} point_t;

	typedef struct packed {
		logic [1:0]    idx;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          last;
	} corner_t;

	fan_phase_t phase;
	point_t     apex;
	point_t     fan_start;
	point_t     middle;
	corner_t    expected_corners[$];
	int         mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic [CW-1:0] floor_half(logic [CW-1:0] p, logic [CW-1:0] q);
		logic signed [CW:0] s;
		s = $signed({p[CW-1], p}) + $signed({q[CW-1], q});
		return s[CW:1];
	endfunction

	function automatic logic [CW-1:0] floor_third(logic [CW-1:0] p, logic [CW-1:0] q,
		logic [CW-1:0] r);
		logic signed [CW+1:0] s;
		logic signed [CW+1:0] quo;
		s = $signed({{2{p[CW-1]}}, p}) + $signed({{2{q[CW-1]}}, q})
			+ $signed({{2{r[CW-1]}}, r});
		quo = s / 3;
		if (s < 0 && (s % 3) != 0)
			quo = quo - 1;
		return quo[CW-1:0];
	endfunction

	function automatic point_t mid_point(point_t a, point_t b);
		point_t m;
		m.x = floor_half(a.x, b.x);
		m.y = floor_half(a.y, b.y);
		m.z = floor_half(a.z, b.z);
		return m;
	endfunction

	function automatic point_t centroid(point_t a, point_t b, point_t c);
		point_t m;
		m.x = floor_third(a.x, b.x, c.x);
		m.y = floor_third(a.y, b.y, c.y);
		m.z = floor_third(a.z, b.z, c.z);
		return m;
	endfunction

	task automatic push_quad(point_t c0, point_t c1, point_t c2, point_t c3, logic last);
		expected_corners.push_back('{2'd0, c0.x, c0.y, c0.z, 1'b0});
		expected_corners.push_back('{2'd1, c1.x, c1.y, c1.z, 1'b0});
		expected_corners.push_back('{2'd2, c2.x, c2.y, c2.z, 1'b0});
		expected_corners.push_back('{2'd3, c3.x, c3.y, c3.z, last});
	endtask

	task automatic predict_vertex(point_t v, logic fin);
		point_t ab;
		point_t bc;
		point_t ac;
		point_t ctr;
		case (phase)
			AWAIT_APEX: begin
				apex = v;
				phase = AWAIT_START;
			end
			AWAIT_START: begin
				fan_start = v;
				phase = AWAIT_MIDDLE;
			end
			AWAIT_MIDDLE: begin
				if (fin) begin
					ab = mid_point(apex, fan_start);
					bc = mid_point(fan_start, v);
					ac = mid_point(apex, v);
					ctr = centroid(apex, fan_start, v);
					push_quad(apex, ab, ac, ctr, 1'b0);
					push_quad(fan_start, ab, bc, ctr, 1'b0);
					push_quad(v, bc, ac, ctr, 1'b1);
				end else begin
					middle = v;
					phase = AWAIT_CLOSE;
				end
			end
			default: begin
				push_quad(apex, fan_start, v, middle, 1'b1);
				fan_start = v;
				phase = AWAIT_MIDDLE;
			end
		endcase
		if (fin)
			phase = AWAIT_APEX;
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_corner(corner_t want);
		check_field("corner_index", want.idx, corner_mon.corner_index);
		check_field("corner_x", $signed(want.x), $signed(corner_mon.corner_x));
		check_field("corner_y", $signed(want.y), $signed(corner_mon.corner_y));
		check_field("corner_z", $signed(want.z), $signed(corner_mon.corner_z));
		check_field("run_last", want.last, corner_mon.run_last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = AWAIT_APEX;
			apex = '0;
			fan_start = '0;
			middle = '0;
			expected_corners.delete();
		end else begin
			if (vertex_mon.valid && vertex_mon.ready)
				predict_vertex('{vertex_mon.pos_x, vertex_mon.pos_y, vertex_mon.pos_z},
					vertex_mon.polygon_end);
			if (corner_mon.valid && corner_mon.ready) begin
				if (expected_corners.size() == 0) begin
					$error("corner transfer with no corner expected");
					mismatches++;
				end else begin
					check_corner(expected_corners.pop_front());
				end
			end
		end
		corners_owed <= expected_corners.size();
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = 32;
	localparam int VERTEX_TARGET = 200;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   corners_owed;
	int   vertices_sent = 0;
	bit   tx_idle_en = 1'b1;
	bit   long_hold_req = 1'b0;

	pftbq_vertex_if #(.COORD_WIDTH(CW)) vertex_ch();
	pftbq_corner_if #(.COORD_WIDTH(CW)) corner_ch();

	polygon_fan_to_bilinear_quads #(.COORD_WIDTH(CW)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex_ch),
		.corner (corner_ch)
	);

	pftbq_quad_checker #(.CW(CW)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_mon   (vertex_ch),
		.corner_mon   (corner_ch),
		.fail_count   (fail_count),
		.corners_owed (corners_owed)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [CW-1:0] rand_coord();
		logic [CW-1:0] c;
		case ($urandom_range(0, 7))
			0: c = {1'b0, {(CW-1){1'b1}}};
			1: c = {1'b1, {(CW-1){1'b0}}};
			2: c = '0;
			3: c = '1;
			4, 5: c = CW'($signed($urandom_range(0, 1023)) - 512);
			default: c = $urandom;
		endcase
		return c;
	endfunction

	task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
		logic fin);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			vertex_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_ch.valid <= 1'b1;
		vertex_ch.pos_x <= x;
		vertex_ch.pos_y <= y;
		vertex_ch.pos_z <= z;
		vertex_ch.polygon_end <= fin;
		@(posedge clk);
		while (!vertex_ch.ready)
			@(posedge clk);
		vertices_sent++;
	endtask

	task automatic send_polygon(int n);
		for (int k = 0; k < n; k++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
	endtask

	// corner receiver
	initial begin
		int  stall;
		int  run;
		bit  rx_idle_en;
		corner_ch.ready <= 1'b0;
		rx_idle_en = 1'b1;
		run = 0;
		@(posedge arst_n);
		forever begin
			if (run == 0) begin
				rx_idle_en = ($urandom_range(0, 3) != 0);
				run = $urandom_range(8, 40);
			end
			run--;
			stall = rx_idle_en ? $urandom_range(0, 4) : 0;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				corner_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			corner_ch.ready <= 1'b1;
			@(posedge clk);
			while (!corner_ch.valid)
				@(posedge clk);
		end
	end

	// vertex sender
	initial begin
		logic [CW-1:0] pmax;
		logic [CW-1:0] pmin;
		int            sel;
		int            n;
		bit            pressure_done;
		pmax = {1'b0, {(CW-1){1'b1}}};
		pmin = {1'b1, {(CW-1){1'b0}}};
		pressure_done = 1'b0;
		arst_n <= 1'b0;
		vertex_ch.valid <= 1'b0;
		vertex_ch.pos_x <= '0;
		vertex_ch.pos_y <= '0;
		vertex_ch.pos_z <= '0;
		vertex_ch.polygon_end <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone vertex, then two-vertex polygon: no corners
		send_vertex(pmax, pmin, '1, 1'b1);
		send_vertex(32'h0001_0000, 32'hffff_0000, '0, 1'b0);
		send_vertex(pmin, pmax, 32'h0000_8000, 1'b1);
		// triangle splits at the range limits
		send_vertex(pmax, pmax, pmax, 1'b0);
		send_vertex(pmax, pmax, pmax, 1'b0);
		send_vertex(pmax, pmax, pmax, 1'b1);
		send_vertex(pmin, pmin, pmin, 1'b0);
		send_vertex(pmin, pmin, pmin, 1'b0);
		send_vertex(pmin, pmin, pmin, 1'b1);
		send_vertex(pmax, pmin, '1, 1'b0);
		send_vertex(pmin, '0, pmax, 1'b0);
		send_vertex('1, pmax, 32'h0000_0001, 1'b1);
		// quad closing on the end mark
		send_vertex('0, '0, '0, 1'b0);
		send_vertex(32'h0001_0000, '0, '0, 1'b0);
		send_vertex(32'h0001_0000, 32'h0001_0000, '0, 1'b0);
		send_vertex('0, 32'h0001_0000, '0, 1'b1);
		// pentagon: one quad then a split
		send_vertex(32'hffff_fffd, 32'h0000_0005, 32'hffff_ffff, 1'b0);
		send_vertex(32'h0000_0007, 32'hffff_fff9, 32'h0000_0002, 1'b0);
		send_vertex(32'h0000_0004, 32'h0000_0001, 32'hffff_fffe, 1'b0);
		send_vertex(32'hffff_ffff, 32'h0000_0002, 32'h0000_0003, 1'b0);
		send_vertex(32'h0000_0002, 32'hffff_fffb, 32'h0000_0001, 1'b1);

		while (vertices_sent < VERTEX_TARGET) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			sel = $urandom_range(0, 9);
			if (sel == 0)
				n = 1;
			else if (sel == 1)
				n = 2;
			else if (sel <= 4)
				n = 3;
			else
				n = $urandom_range(4, 9);
			if (!pressure_done && vertices_sent >= VERTEX_TARGET / 2) begin
				pressure_done = 1'b1;
				long_hold_req = 1'b1;
				tx_idle_en = 1'b0;
				n = 12;
			end
			send_polygon(n);
		end
		vertex_ch.valid <= 1'b0;

		@(posedge clk);
		while (corners_owed != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
